// ===== rtl/asac_pkg.sv =====
// ----------------------------------------------------------------------------
// asac_pkg
// Shared types and constants for the acute set admission check.
// ----------------------------------------------------------------------------
package asac_pkg;

  localparam int MaxPoints = 64;
  localparam int MaxDim    = 16;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);

  localparam logic [2:0] ST_ADDED       = 3'd0;
  localparam logic [2:0] ST_DUP         = 3'd1;
  localparam logic [2:0] ST_APEX_CAND   = 3'd2;
  localparam logic [2:0] ST_APEX_MEMBER = 3'd3;
  localparam logic [2:0] ST_FULL        = 3'd4;
  localparam logic [2:0] ST_CLEARED     = 3'd5;

  localparam logic REQ_CLEAR = 1'b0;
  localparam logic REQ_ADD   = 1'b1;

  localparam logic CFG_DIMENSION   = 1'b0;
  localparam logic CFG_TARGET_SIZE = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] candidate;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] set_size;
  } out_beat_t;

  // control carried along the chain of cells
  typedef struct packed {
    logic        shift;   // rotate the ring by one place
    logic        load;    // append the candidate at the chain tail
    logic [15:0] probe;   // vertex broadcast to every cell
    logic [15:0] cand;    // candidate vertex
  } cell_ctl_t;

endpackage

// ===== rtl/asac_cell.sv =====
// ----------------------------------------------------------------------------
// asac_cell
// One chain cell: holds a member, passes it on, tests it against a probe.
// ----------------------------------------------------------------------------
module asac_cell
  import asac_pkg::*;
(
  input  logic        clk,
  input  cell_ctl_t   ctl,
  input  logic [15:0] prev_pt,
  input  logic        is_tail,
  input  logic        in_set,
  output logic [15:0] pt,
  output logic        hit_dup,
  output logic        hit_cand,
  output logic        hit_member
);

  logic [15:0] pt_r;
  logic [15:0] pt_nxt;

  // ring shift, or write at the tail on append
  always_comb begin
    pt_nxt = pt_r;
    if (ctl.load && is_tail) begin
      pt_nxt = ctl.cand;
    end else if (ctl.shift) begin
      pt_nxt = prev_pt;
    end
  end

  always_ff @(posedge clk) begin
    pt_r <= pt_nxt;
  end

  assign pt = pt_r;

  // apex at candidate: probe is member a; this cell holds member b
  // apex at member: probe is member q as apex, legs candidate and this cell
  assign hit_dup    = in_set && (pt_r == ctl.cand);
  assign hit_cand   = in_set && (((ctl.probe ^ ctl.cand) & (pt_r ^ ctl.cand)) == '0);
  assign hit_member = in_set && (((ctl.cand ^ ctl.probe) & (pt_r ^ ctl.probe)) == '0);

endmodule

// ===== rtl/asac_chain.sv =====
// ----------------------------------------------------------------------------
// asac_chain
// Row of cells forming a rotating ring of the stored members.
// ----------------------------------------------------------------------------
module asac_chain
  import asac_pkg::*;
(
  input  logic                 clk,
  input  cell_ctl_t            ctl,
  input  logic [CntW-1:0]      count,
  output logic [15:0]          head_pt,
  output logic [MaxPoints-1:0] dup_v,
  output logic [MaxPoints-1:0] cand_v,
  output logic [MaxPoints-1:0] member_v
);

  logic [15:0] pts [MaxPoints];

  // cells in use rotate among themselves: cell 0 takes from the last used one
  for (genvar i = 0; i < MaxPoints; i++) begin : g_cell
    logic [15:0] prev;
    logic        used;
    if (i == 0) begin : g_head
      always_comb begin
        prev = pts[0];
        for (int j = 0; j < MaxPoints; j++) begin
          if (CntW'(j + 1) == count) prev = pts[j];
        end
      end
    end else begin : g_body
      assign prev = pts[i-1];
    end
    assign used = CntW'(i) < count;
    asac_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .prev_pt   (prev),
      .is_tail   (CntW'(i) == count),
      .in_set    (used),
      .pt        (pts[i]),
      .hit_dup   (dup_v[i]),
      .hit_cand  (cand_v[i]),
      .hit_member(member_v[i])
    );
  end

  assign head_pt = pts[0];

endmodule

// ===== rtl/acute_set_admission_check_top.sv =====
// ----------------------------------------------------------------------------
// acute_set_admission_check_top
// Admission check of hypercube vertices into a set with no right angle.
// ----------------------------------------------------------------------------
//  channel | ports                        | beat
//  in      | in_valid/in_ready/in_data    | req_type, candidate
//  out     | out_valid/out_ready/out_data | status, set_size
//  cfg     | cfg_we/cfg_index/cfg_data    | dimension, target_size
//
//  A clear, or an add of a duplicate or into a full set, answers from idle;
//  other adds pass twice over the ring of m members, appending if no hit.
//  Each pass cycle compares the member at the ring head with every cell.
//  rst_n is synchronous; it empties the set and restores register defaults.
//  The result waits in an output register; the next beat is taken once it goes.
module acute_set_admission_check_top
  import asac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_beat_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_beat_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_PASS_A, S_PASS_Q, S_DONE} state_t;

  state_t          state_r;
  logic [4:0]      dim_r;
  logic [6:0]      tgt_r;
  logic [CntW-1:0] count_r;
  logic [IdxW-1:0] step_r;
  logic [15:0]     cand_r;
  logic            out_valid_r;
  out_beat_t       out_r;

  cell_ctl_t            ctl;
  logic [15:0]          head_pt;
  logic [MaxPoints-1:0] dup_v, cand_v, member_v;
  logic [15:0]          mask, x;
  logic [MaxPoints-1:0] later_mask, other_mask;
  logic [6:0]           limit;

  // dimension mask, capped at the vertex width
  always_comb begin
    mask = '1;
    if (dim_r < 5'(MaxDim)) mask = 16'((17'd1 << dim_r) - 17'd1);
  end
  assign x     = in_data.candidate & mask;
  assign limit = (tgt_r > 7'(MaxPoints)) ? 7'(MaxPoints) : tgt_r;

  // after step rotations the head holds member (m-step) mod m and cell k holds
  // (k-step) mod m, so the members above the head sit in cells 1 to step-1
  // (every other cell on the first step)
  always_comb begin
    for (int k = 0; k < MaxPoints; k++) begin
      later_mask[k] = (k != 0) && ((step_r == '0) || (IdxW'(k) < step_r));
      other_mask[k] = (k != 0);
    end
  end

  assign ctl.probe = head_pt;
  assign ctl.cand  = (state_r == S_IDLE) ? x : cand_r;
  assign ctl.shift = (state_r == S_PASS_A) || (state_r == S_PASS_Q);
  assign ctl.load  = (state_r == S_DONE);

  asac_chain u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .count   (count_r),
    .head_pt (head_pt),
    .dup_v   (dup_v),
    .cand_v  (cand_v),
    .member_v(member_v)
  );

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequencer, registers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dim_r       <= 5'd15;
      tgt_r       <= 7'd64;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIMENSION:   dim_r <= cfg_data[4:0];
          CFG_TARGET_SIZE: tgt_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cand_r <= x;
            step_r <= '0;
            if (in_data.req_type == REQ_CLEAR) begin
              count_r     <= '0;
              out_r       <= '{ST_CLEARED, 7'd0};
              out_valid_r <= 1'b1;
            end else if (|dup_v) begin
              out_r       <= '{ST_DUP, 7'(count_r)};
              out_valid_r <= 1'b1;
            end else if (7'(count_r) >= limit) begin
              out_r       <= '{ST_FULL, 7'(count_r)};
              out_valid_r <= 1'b1;
            end else if (count_r == '0) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_PASS_A;
            end
          end
        end
        S_PASS_A: begin
          if (|(cand_v & later_mask)) begin
            out_r       <= '{ST_APEX_CAND, 7'(count_r)};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else if (CntW'(step_r) == count_r - CntW'(1)) begin
            step_r  <= '0;
            state_r <= S_PASS_Q;
          end else begin
            step_r <= step_r + IdxW'(1);
          end
        end
        S_PASS_Q: begin
          if (|(member_v & other_mask)) begin
            out_r       <= '{ST_APEX_MEMBER, 7'(count_r)};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else if (CntW'(step_r) == count_r - CntW'(1)) begin
            step_r  <= '0;
            state_r <= S_DONE;
          end else begin
            step_r <= step_r + IdxW'(1);
          end
        end
        S_DONE: begin
          count_r     <= count_r + CntW'(1);
          out_r       <= '{ST_ADDED, 7'(count_r + CntW'(1))};
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // set never grows past the store
  a_count_cap : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MaxPoints)) else $error("set count beyond store");

  // no new beat while a result is held
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ready) else $error("accept while result pending");

  // an append raises the count by one
  a_append : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> (count_r == $past(count_r) + CntW'(1)))
    else $error("append count slip");

endmodule
